// File: hdl/snfcs_pkg.sv
// Package for the SPI NOR flash command sequencer.
// Beat types, request and result codes, flash command bytes and result builders.
// No dependencies.
package snfcs_pkg;

  localparam int PAGE_SIZE_DEF = 256;

  typedef enum logic [3:0] {
    OP_DEVID      = 4'd0,
    OP_JEDEC      = 4'd1,
    OP_RD_STATUS  = 4'd2,
    OP_WR_STATUS  = 4'd3,
    OP_ERASE      = 4'd4,
    OP_PROG_START = 4'd5,
    OP_PROG_BYTE  = 4'd6,
    OP_READ       = 4'd7,
    OP_RX         = 4'd8
  } op_e;

  localparam logic [2:0] ACT_ERASE = 3'(OP_ERASE);

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_RDSR0 = 8'h05;
  localparam logic [7:0] CMD_RDSR1 = 8'h35;
  localparam logic [7:0] CMD_WRSR  = 8'h01;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_SE    = 8'h20;
  localparam logic [7:0] CMD_DEVID = 8'hAB;
  localparam logic [7:0] CMD_JEDEC = 8'h9F;
  localparam logic [7:0] DUMMY     = 8'h00;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [23:0] flash_address;
    logic [15:0] byte_count;
    logic        status_select;
    logic [15:0] status_word;
    logic [7:0]  data_byte;
    logic [7:0]  rx_byte;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic        release_select;
    logic [23:0] reply_value;
    logic        last;
  } out_t;

  // Results of one item handed to the output queue.
  typedef struct packed {
    logic [1:0] cnt;
    out_t       r0;
    out_t       r1;
  } push_t;

  function automatic out_t mk_res(kind_e k, logic [7:0] b, logic rel, logic [23:0] v);
    out_t r;
    r.kind           = k;
    r.tx_byte        = b;
    r.release_select = rel;
    r.reply_value    = v;
    r.last           = 1'b0;
    return r;
  endfunction

  function automatic out_t tx_res(logic [7:0] b, logic rel);
    return mk_res(KIND_TX, b, rel, 24'd0);
  endfunction

  function automatic out_t reply_res(logic [23:0] v);
    return mk_res(KIND_REPLY, DUMMY, 1'b0, v);
  endfunction

  function automatic out_t done_res();
    return mk_res(KIND_DONE, DUMMY, 1'b0, 24'd0);
  endfunction

endpackage

// File: hdl/snfcs_core.sv
// Sequencer state and per-beat step logic: one input beat in, up to two results out.
// Depends on snfcs_pkg. PAGE_SIZE is a power of two.
module snfcs_core #(
  parameter int PAGE_SIZE = snfcs_pkg::PAGE_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             proc_i,
  input  snfcs_pkg::in_t   item_i,
  output snfcs_pkg::push_t push_o
);
  import snfcs_pkg::*;

  localparam int PBL_W = $clog2(PAGE_SIZE + 1);
  localparam int OFF_W = $clog2(PAGE_SIZE);

  typedef enum logic [35:0] {
    ST_IDLE     = 36'h1 << 0,
    ST_DEV0     = 36'h1 << 1,
    ST_DEV1     = 36'h1 << 2,
    ST_DEV2     = 36'h1 << 3,
    ST_DEV3     = 36'h1 << 4,
    ST_DEV4     = 36'h1 << 5,
    ST_JED0     = 36'h1 << 6,
    ST_JED1     = 36'h1 << 7,
    ST_JED2     = 36'h1 << 8,
    ST_JED3     = 36'h1 << 9,
    ST_RS0      = 36'h1 << 10,
    ST_RS1      = 36'h1 << 11,
    ST_WS_WREN  = 36'h1 << 12,
    ST_WS_CMD   = 36'h1 << 13,
    ST_WS_LO    = 36'h1 << 14,
    ST_WS_HI    = 36'h1 << 15,
    ST_ER_WREN  = 36'h1 << 16,
    ST_ER_CMD   = 36'h1 << 17,
    ST_ER_A2    = 36'h1 << 18,
    ST_ER_A1    = 36'h1 << 19,
    ST_ER_A0    = 36'h1 << 20,
    ST_PG_WREN  = 36'h1 << 21,
    ST_PG_CMD   = 36'h1 << 22,
    ST_PG_A2    = 36'h1 << 23,
    ST_PG_A1    = 36'h1 << 24,
    ST_PG_A0    = 36'h1 << 25,
    ST_PG_WAIT  = 36'h1 << 26,
    ST_PG_DATA  = 36'h1 << 27,
    ST_RD_CMD   = 36'h1 << 28,
    ST_RD_A2    = 36'h1 << 29,
    ST_RD_A1    = 36'h1 << 30,
    ST_RD_A0    = 36'h1 << 31,
    ST_RD_DATA  = 36'h1 << 32,
    ST_POLL_CMD = 36'h1 << 33,
    ST_POLL_RD  = 36'h1 << 34,
    ST_POLL_END = 36'h1 << 35
  } step_e;

  step_e             step_q, step_d;
  logic [2:0]        act_q, act_d;
  logic [23:0]       addr_q, addr_d;
  logic [15:0]       brem_q, brem_d;
  logic [PBL_W-1:0]  pbl_q, pbl_d;
  logic [23:0]       id_q, id_d;
  logic [15:0]       pstat_q, pstat_d;

  // Bytes up to the next page boundary, capped by the remaining count.
  function automatic logic [PBL_W-1:0] chunk_f(logic [23:0] a, logic [15:0] c);
    logic [PBL_W-1:0] room;
    room = PBL_W'(PAGE_SIZE) - PBL_W'(a[OFF_W-1:0]);
    if ({1'b0, c} < 17'(room)) begin
      return PBL_W'(c);
    end
    return room;
  endfunction

  always_comb begin
    out_t        r0, r1;
    logic [1:0]  n;
    logic [15:0] brem_n;
    logic [7:0]  rx;

    step_d  = step_q;
    act_d   = act_q;
    addr_d  = addr_q;
    brem_d  = brem_q;
    pbl_d   = pbl_q;
    id_d    = id_q;
    pstat_d = pstat_q;
    r0      = done_res();
    r1      = done_res();
    n       = 2'd0;
    rx      = item_i.rx_byte;
    brem_n  = brem_q - 16'd1;

    if (proc_i) begin
      if (item_i.opcode == OP_RX) begin
        unique case (step_q)
          ST_DEV0:    begin step_d = ST_DEV1; r0 = tx_res(DUMMY, 1'b0); n = 2'd1; end
          ST_DEV1:    begin step_d = ST_DEV2; r0 = tx_res(DUMMY, 1'b0); n = 2'd1; end
          ST_DEV2:    begin step_d = ST_DEV3; r0 = tx_res(DUMMY, 1'b0); n = 2'd1; end
          ST_DEV3:    begin step_d = ST_DEV4; r0 = tx_res(DUMMY, 1'b1); n = 2'd1; end
          ST_DEV4, ST_RS1: begin
            step_d = ST_IDLE;
            r0 = reply_res({16'd0, rx});
            n = 2'd2;
          end
          ST_JED0:    begin step_d = ST_JED1; r0 = tx_res(DUMMY, 1'b0); n = 2'd1; end
          ST_JED1: begin
            id_d = {rx, 16'd0};
            step_d = ST_JED2;
            r0 = tx_res(DUMMY, 1'b0);
            n = 2'd1;
          end
          ST_JED2: begin
            id_d = id_q | {8'd0, rx, 8'd0};
            step_d = ST_JED3;
            r0 = tx_res(DUMMY, 1'b1);
            n = 2'd1;
          end
          ST_JED3: begin
            id_d = id_q | {16'd0, rx};
            step_d = ST_IDLE;
            r0 = reply_res(id_q | {16'd0, rx});
            n = 2'd2;
          end
          ST_RS0:     begin step_d = ST_RS1; r0 = tx_res(DUMMY, 1'b1); n = 2'd1; end
          ST_WS_WREN: begin step_d = ST_WS_CMD; r0 = tx_res(CMD_WRSR, 1'b0); n = 2'd1; end
          ST_WS_CMD: begin
            step_d = ST_WS_LO;
            r0 = tx_res(pstat_q[7:0], 1'b0);
            n = 2'd1;
          end
          ST_WS_LO: begin
            step_d = ST_WS_HI;
            r0 = tx_res(pstat_q[15:8], 1'b1);
            n = 2'd1;
          end
          ST_WS_HI:   begin step_d = ST_IDLE; n = 2'd1; end
          ST_ER_WREN: begin step_d = ST_POLL_CMD; r0 = tx_res(CMD_RDSR0, 1'b0); n = 2'd1; end
          ST_ER_CMD:  begin step_d = ST_ER_A2; r0 = tx_res(addr_q[23:16], 1'b0); n = 2'd1; end
          ST_ER_A2:   begin step_d = ST_ER_A1; r0 = tx_res(addr_q[15:8], 1'b0); n = 2'd1; end
          ST_ER_A1:   begin step_d = ST_ER_A0; r0 = tx_res(addr_q[7:0], 1'b1); n = 2'd1; end
          ST_ER_A0: begin
            brem_d = 16'd0;
            step_d = ST_POLL_CMD;
            r0 = tx_res(CMD_RDSR0, 1'b0);
            n = 2'd1;
          end
          ST_PG_WREN: begin step_d = ST_PG_CMD; r0 = tx_res(CMD_PP, 1'b0); n = 2'd1; end
          ST_PG_CMD:  begin step_d = ST_PG_A2; r0 = tx_res(addr_q[23:16], 1'b0); n = 2'd1; end
          ST_PG_A2:   begin step_d = ST_PG_A1; r0 = tx_res(addr_q[15:8], 1'b0); n = 2'd1; end
          ST_PG_A1: begin
            step_d = ST_PG_A0;
            r0 = tx_res(addr_q[7:0], pbl_q == '0);
            n = 2'd1;
          end
          ST_PG_A0, ST_PG_DATA: begin
            if (pbl_q != '0) begin
              step_d = ST_PG_WAIT;
            end else begin
              step_d = ST_POLL_CMD;
              r0 = tx_res(CMD_RDSR0, 1'b0);
              n = 2'd1;
            end
          end
          ST_RD_CMD:  begin step_d = ST_RD_A2; r0 = tx_res(addr_q[23:16], 1'b0); n = 2'd1; end
          ST_RD_A2:   begin step_d = ST_RD_A1; r0 = tx_res(addr_q[15:8], 1'b0); n = 2'd1; end
          ST_RD_A1: begin
            step_d = ST_RD_A0;
            r0 = tx_res(addr_q[7:0], brem_q == 16'd0);
            n = 2'd1;
          end
          ST_RD_A0: begin
            if (brem_q == 16'd0) begin
              step_d = ST_IDLE;
              n = 2'd1;
            end else begin
              step_d = ST_RD_DATA;
              r0 = tx_res(DUMMY, brem_q == 16'd1);
              n = 2'd1;
            end
          end
          ST_RD_DATA: begin
            r0 = reply_res({16'd0, rx});
            brem_d = brem_n;
            n = 2'd2;
            if (brem_n == 16'd0) begin
              step_d = ST_IDLE;
            end else begin
              r1 = tx_res(DUMMY, brem_n == 16'd1);
            end
          end
          ST_POLL_CMD: begin step_d = ST_POLL_RD; r0 = tx_res(DUMMY, 1'b0); n = 2'd1; end
          ST_POLL_RD: begin
            n = 2'd1;
            if (rx[0]) begin
              r0 = tx_res(DUMMY, 1'b0);
            end else begin
              step_d = ST_POLL_END;
              r0 = tx_res(DUMMY, 1'b1);
            end
          end
          ST_POLL_END: begin
            n = 2'd1;
            if (brem_q == 16'd0) begin
              step_d = ST_IDLE;
            end else if (act_q == ACT_ERASE) begin
              step_d = ST_ER_CMD;
              r0 = tx_res(CMD_SE, 1'b0);
            end else begin
              pbl_d = chunk_f(addr_q, brem_q);
              step_d = ST_PG_WREN;
              r0 = tx_res(CMD_WREN, 1'b1);
            end
          end
          default: ;
        endcase
      end else if (item_i.opcode == OP_PROG_BYTE) begin
        if (step_q == ST_PG_WAIT) begin
          r0 = tx_res(item_i.data_byte, pbl_q == PBL_W'(1));
          n = 2'd1;
          pbl_d = pbl_q - PBL_W'(1);
          brem_d = brem_n;
          addr_d = addr_q + 24'd1;
          step_d = ST_PG_DATA;
        end
      end else if (item_i.opcode <= OP_READ && step_q == ST_IDLE) begin
        act_d = item_i.opcode[2:0];
        n = 2'd1;
        unique case (item_i.opcode)
          OP_DEVID: begin step_d = ST_DEV0; r0 = tx_res(CMD_DEVID, 1'b0); end
          OP_JEDEC: begin
            id_d = 24'd0;
            step_d = ST_JED0;
            r0 = tx_res(CMD_JEDEC, 1'b0);
          end
          OP_RD_STATUS: begin
            step_d = ST_RS0;
            r0 = tx_res(item_i.status_select ? CMD_RDSR1 : CMD_RDSR0, 1'b0);
          end
          OP_WR_STATUS: begin
            pstat_d = item_i.status_word;
            step_d = ST_WS_WREN;
            r0 = tx_res(CMD_WREN, 1'b1);
          end
          OP_ERASE: begin
            addr_d = item_i.flash_address;
            brem_d = 16'd1;
            step_d = ST_ER_WREN;
            r0 = tx_res(CMD_WREN, 1'b1);
          end
          OP_PROG_START: begin
            addr_d = item_i.flash_address;
            brem_d = item_i.byte_count;
            pbl_d = chunk_f(item_i.flash_address, item_i.byte_count);
            step_d = ST_PG_WREN;
            r0 = tx_res(CMD_WREN, 1'b1);
          end
          OP_READ: begin
            addr_d = item_i.flash_address;
            brem_d = item_i.byte_count;
            step_d = ST_RD_CMD;
            r0 = tx_res(CMD_READ, 1'b0);
          end
          default: n = 2'd0;
        endcase
      end
    end

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
    push_o.cnt = n;
    push_o.r0  = r0;
    push_o.r1  = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_IDLE;
      act_q   <= '0;
      addr_q  <= '0;
      brem_q  <= '0;
      pbl_q   <= '0;
      id_q    <= '0;
      pstat_q <= '0;
    end else begin
      step_q  <= step_d;
      act_q   <= act_d;
      addr_q  <= addr_d;
      brem_q  <= brem_d;
      pbl_q   <= pbl_d;
      id_q    <= id_d;
      pstat_q <= pstat_d;
    end
  end

  a_wait_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == ST_PG_WAIT |-> pbl_q != '0)
    else $error("program data awaited with empty page count");

  a_read_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == ST_RD_DATA |-> brem_q != 16'd0)
    else $error("read data phase with zero bytes remaining");

  a_pair_is_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |-> (push_o.r0.kind == KIND_REPLY && push_o.r1.last && !push_o.r0.last))
    else $error("two results without leading reply");

endmodule

// File: hdl/snfcs_outq.sv
// Four-entry result queue: up to two results in a cycle, one beat out a cycle unless stalled.
// Depends on snfcs_pkg.
module snfcs_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  snfcs_pkg::push_t push_i,
  output logic             room2_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output snfcs_pkg::out_t  out_o
);
  import snfcs_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rp_q];
  assign room2_o     = cnt_q <= CNT_W'(DEPTH - 2);

  always_comb begin
    wp_d  = wp_q + PTR_W'(push_i.cnt);
    rp_d  = rp_q + PTR_W'(pop);
    cnt_d = cnt_q + CNT_W'(push_i.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wp_q + PTR_W'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> cnt_q <= CNT_W'(DEPTH - 2))
    else $error("result queue pushed without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH) && (wp_q - rp_q) == PTR_W'(cnt_q))
    else $error("result queue pointers and count disagree");

endmodule

// File: hdl/spi_nor_flash_command_sequencer.sv
// Top level of the SPI NOR flash command sequencer (3-byte addressing).
// Depends on snfcs_pkg, snfcs_core and snfcs_outq.
//
//   channel  direction  beat    handshake
//   in       input      in_t    in_valid_i / in_stall_o
//   out      output     out_t   out_valid_o / out_stall_i
//
// One input beat is taken per clock unless in_stall_o is high; it is held in the input
// register and processed once the queue has two free entries; 0, 1 or 2 results go
// to the 4-entry queue. Results leave one per unstalled clock; the output bounds the rate.
// in_stall_o rises while the input register holds a beat and the queue has fewer
// than two free entries. Reset is asynchronous and returns the sequencer to idle.
module spi_nor_flash_command_sequencer #(
  parameter int PAGE_SIZE = snfcs_pkg::PAGE_SIZE_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  snfcs_pkg::in_t  in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output snfcs_pkg::out_t out_o
);
  import snfcs_pkg::*;

  logic  in_vld_q, in_vld_d;
  in_t   in_q;
  logic  room2;
  logic  proc;
  logic  accept;
  push_t push;

  assign proc       = in_vld_q && room2;
  assign in_stall_o = in_vld_q && !room2;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept || (in_vld_q && !proc);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  snfcs_core #(
    .PAGE_SIZE(PAGE_SIZE)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .proc_i (proc),
    .item_i (in_q),
    .push_o (push)
  );

  snfcs_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

// File: tb/sv/spi_nor_flash_command_sequencer_tb.sv
// Testbench for the SPI NOR flash command sequencer: a directed table, then random requests.
// The host and flash sides are driven here; every output beat is checked against the table or a local model.
// Depends on snfcs_pkg and spi_nor_flash_command_sequencer.
`timescale 1ns / 100ps

module spi_nor_flash_command_sequencer_tb;
  import snfcs_pkg::*;

  localparam int PAGE        = PAGE_SIZE_DEF;
  localparam int RANDOM_BEATS = 1030;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 32;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_DEV0, ST_DEV1, ST_DEV2, ST_DEV3, ST_DEV4,
    ST_JED0, ST_JED1, ST_JED2, ST_JED3,
    ST_RS0, ST_RS1,
    ST_WS_WREN, ST_WS_CMD, ST_WS_LO, ST_WS_HI,
    ST_ER_WREN, ST_ER_CMD, ST_ER_A2, ST_ER_A1, ST_ER_A0,
    ST_PG_WREN, ST_PG_CMD, ST_PG_A2, ST_PG_A1, ST_PG_A0, ST_PG_WAIT, ST_PG_DATA,
    ST_RD_CMD, ST_RD_A2, ST_RD_A1, ST_RD_A0, ST_RD_DATA,
    ST_POLL_CMD, ST_POLL_READ, ST_POLL_END
  } seq_e;

  typedef enum {DRAIN_NONE, DRAIN_WAIT, DRAIN_IDLE} drain_e;

  typedef struct {
    in_t    beat;
    int     n_typed;
    out_t   want;
    drain_e drain;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_o;

  // model state
  seq_e        seq;
  logic [2:0]  req;
  logic [23:0] cur_addr;
  logic [15:0] remaining;
  int          page_left;
  logic [23:0] id_acc;
  logic [15:0] status_hold;

  out_t got_r[2];
  int   got_n;
  out_t flash_beats_due[$];
  row_t rows[$];
  int   mismatches;
  bit   steady;
  bit   hold_off_req;

  spi_nor_flash_command_sequencer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 100) begin
      $display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  function automatic out_t flash_beat(kind_e k, logic [7:0] d, logic rel, logic [23:0] v,
                                      logic lst);
    out_t r;
    r.kind           = k;
    r.tx_byte        = d;
    r.release_select = rel;
    r.reply_value    = v;
    r.last           = lst;
    return r;
  endfunction

  function automatic in_t mk_req(logic [3:0] op, logic [23:0] a, logic [15:0] c, logic s,
                                 logic [15:0] w, logic [7:0] d, logic [7:0] r);
    in_t b;
    b.opcode        = op;
    b.flash_address = a;
    b.byte_count    = c;
    b.status_select = s;
    b.status_word   = w;
    b.data_byte     = d;
    b.rx_byte       = r;
    return b;
  endfunction

  function automatic in_t rand_fields(logic [3:0] op);
    return mk_req(op, 24'($urandom), 16'($urandom), 1'($urandom), 16'($urandom),
                  8'($urandom), 8'($urandom));
  endfunction

  function automatic void add_row(in_t b, int n_typed, out_t want, drain_e d);
    row_t r;
    r.beat    = b;
    r.n_typed = n_typed;
    r.want    = want;
    r.drain   = d;
    rows.push_back(r);
  endfunction

  function automatic void add_beat(kind_e k, logic [7:0] d, logic rel, logic [23:0] v);
    got_r[got_n] = flash_beat(k, d, rel, v, 1'b0);
    got_n++;
  endfunction

  function automatic void add_tx(logic [7:0] d, logic rel);
    add_beat(KIND_TX, d, rel, 24'h0);
  endfunction

  function automatic void close_request();
    seq = ST_IDLE;
    add_beat(KIND_DONE, DUMMY, 1'b0, 24'h0);
  endfunction

  function automatic int page_chunk();
    int room;
    room = PAGE - (int'(cur_addr) % PAGE);
    return (int'(remaining) < room) ? int'(remaining) : room;
  endfunction

  // Advances the local model by one input beat; results land in got_r/got_n.
  function automatic void predict_flash_beats(input in_t b, output bit effective);
    seq_e was;
    was   = seq;
    got_n = 0;
    if (b.opcode == OP_RX) begin
      case (seq)
        ST_DEV0: begin seq = ST_DEV1; add_tx(DUMMY, 1'b0); end
        ST_DEV1: begin seq = ST_DEV2; add_tx(DUMMY, 1'b0); end
        ST_DEV2: begin seq = ST_DEV3; add_tx(DUMMY, 1'b0); end
        ST_DEV3: begin seq = ST_DEV4; add_tx(DUMMY, 1'b1); end
        ST_DEV4, ST_RS1: begin
          add_beat(KIND_REPLY, DUMMY, 1'b0, {16'h0, b.rx_byte});
          close_request();
        end
        ST_JED0: begin seq = ST_JED1; add_tx(DUMMY, 1'b0); end
        ST_JED1: begin
          id_acc = {b.rx_byte, 16'h0};
          seq    = ST_JED2;
          add_tx(DUMMY, 1'b0);
        end
        ST_JED2: begin
          id_acc = id_acc | {8'h0, b.rx_byte, 8'h0};
          seq    = ST_JED3;
          add_tx(DUMMY, 1'b1);
        end
        ST_JED3: begin
          id_acc = id_acc | {16'h0, b.rx_byte};
          add_beat(KIND_REPLY, DUMMY, 1'b0, id_acc);
          close_request();
        end
        ST_RS0: begin seq = ST_RS1; add_tx(DUMMY, 1'b1); end
        ST_WS_WREN: begin seq = ST_WS_CMD; add_tx(CMD_WRSR, 1'b0); end
        ST_WS_CMD: begin seq = ST_WS_LO; add_tx(status_hold[7:0], 1'b0); end
        ST_WS_LO: begin seq = ST_WS_HI; add_tx(status_hold[15:8], 1'b1); end
        ST_WS_HI: close_request();
        ST_ER_WREN: begin seq = ST_POLL_CMD; add_tx(CMD_RDSR0, 1'b0); end
        ST_ER_CMD: begin seq = ST_ER_A2; add_tx(cur_addr[23:16], 1'b0); end
        ST_ER_A2: begin seq = ST_ER_A1; add_tx(cur_addr[15:8], 1'b0); end
        ST_ER_A1: begin seq = ST_ER_A0; add_tx(cur_addr[7:0], 1'b1); end
        ST_ER_A0: begin
          remaining = 16'h0;
          seq       = ST_POLL_CMD;
          add_tx(CMD_RDSR0, 1'b0);
        end
        ST_PG_WREN: begin seq = ST_PG_CMD; add_tx(CMD_PP, 1'b0); end
        ST_PG_CMD: begin seq = ST_PG_A2; add_tx(cur_addr[23:16], 1'b0); end
        ST_PG_A2: begin seq = ST_PG_A1; add_tx(cur_addr[15:8], 1'b0); end
        ST_PG_A1: begin seq = ST_PG_A0; add_tx(cur_addr[7:0], page_left == 0); end
        ST_PG_A0, ST_PG_DATA: begin
          if (page_left != 0) begin
            seq = ST_PG_WAIT;
          end else begin
            seq = ST_POLL_CMD;
            add_tx(CMD_RDSR0, 1'b0);
          end
        end
        ST_RD_CMD: begin seq = ST_RD_A2; add_tx(cur_addr[23:16], 1'b0); end
        ST_RD_A2: begin seq = ST_RD_A1; add_tx(cur_addr[15:8], 1'b0); end
        ST_RD_A1: begin seq = ST_RD_A0; add_tx(cur_addr[7:0], remaining == 16'h0); end
        ST_RD_A0: begin
          if (remaining == 16'h0) begin
            close_request();
          end else begin
            seq = ST_RD_DATA;
            add_tx(DUMMY, remaining == 16'h1);
          end
        end
        ST_RD_DATA: begin
          add_beat(KIND_REPLY, DUMMY, 1'b0, {16'h0, b.rx_byte});
          remaining = remaining - 16'h1;
          if (remaining == 16'h0) begin
            close_request();
          end else begin
            add_tx(DUMMY, remaining == 16'h1);
          end
        end
        ST_POLL_CMD: begin seq = ST_POLL_READ; add_tx(DUMMY, 1'b0); end
        ST_POLL_READ: begin
          if (b.rx_byte[0]) begin
            add_tx(DUMMY, 1'b0);
          end else begin
            seq = ST_POLL_END;
            add_tx(DUMMY, 1'b1);
          end
        end
        ST_POLL_END: begin
          if (req == ACT_ERASE) begin
            if (remaining != 16'h0) begin
              seq = ST_ER_CMD;
              add_tx(CMD_SE, 1'b0);
            end else begin
              close_request();
            end
          end else if (remaining != 16'h0) begin
            page_left = page_chunk();
            seq       = ST_PG_WREN;
            add_tx(CMD_WREN, 1'b1);
          end else begin
            close_request();
          end
        end
        default: ;
      endcase
    end else if (b.opcode == OP_PROG_BYTE) begin
      if (seq == ST_PG_WAIT) begin
        add_tx(b.data_byte, page_left == 1);
        page_left--;
        remaining = remaining - 16'h1;
        cur_addr  = cur_addr + 24'h1;
        seq       = ST_PG_DATA;
      end
    end else if (b.opcode <= OP_READ && seq == ST_IDLE) begin
      req = b.opcode[2:0];
      case (b.opcode)
        OP_DEVID: begin seq = ST_DEV0; add_tx(CMD_DEVID, 1'b0); end
        OP_JEDEC: begin id_acc = 24'h0; seq = ST_JED0; add_tx(CMD_JEDEC, 1'b0); end
        OP_RD_STATUS: begin
          seq = ST_RS0;
          add_tx(b.status_select ? CMD_RDSR1 : CMD_RDSR0, 1'b0);
        end
        OP_WR_STATUS: begin
          status_hold = b.status_word;
          seq         = ST_WS_WREN;
          add_tx(CMD_WREN, 1'b1);
        end
        OP_ERASE: begin
          cur_addr  = b.flash_address;
          remaining = 16'h1;
          seq       = ST_ER_WREN;
          add_tx(CMD_WREN, 1'b1);
        end
        OP_PROG_START: begin
          cur_addr  = b.flash_address;
          remaining = b.byte_count;
          page_left = page_chunk();
          seq       = ST_PG_WREN;
          add_tx(CMD_WREN, 1'b1);
        end
        OP_READ: begin
          cur_addr  = b.flash_address;
          remaining = b.byte_count;
          seq       = ST_RD_CMD;
          add_tx(CMD_READ, 1'b0);
        end
        default: ;
      endcase
    end
    if (got_n > 0) got_r[got_n - 1].last = 1'b1;
    effective = (got_n > 0) || (seq != was);
  endfunction

  // Well-formed flash side: data while a page waits, otherwise the rx byte of the last transfer.
  function automatic in_t flash_reply_beat();
    in_t b;
    if (seq == ST_PG_WAIT) begin
      b = rand_fields(OP_PROG_BYTE);
    end else begin
      b = rand_fields(OP_RX);
      if (seq == ST_POLL_READ) b.rx_byte[0] = ($urandom_range(99) < 35);
    end
    return b;
  endfunction

  // n_typed < 0: expectation from the model; otherwise n_typed copies of want.
  task automatic issue_beat(input in_t b, input int n_typed, input out_t want,
                            output bit effective);
    predict_flash_beats(b, effective);
    if (n_typed >= 0) begin
      for (int i = 0; i < n_typed; i++) flash_beats_due.push_back(want);
    end else begin
      for (int i = 0; i < got_n; i++) flash_beats_due.push_back(got_r[i]);
    end
    while (!steady && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (flash_beats_due.size() == 0) begin
        report_mismatch("unexpected beat, kind", 32'(out_o.kind), 32'h0);
      end else begin
        want = flash_beats_due.pop_front();
        if (out_o.kind !== want.kind)
          report_mismatch("kind", 32'(out_o.kind), 32'(want.kind));
        if (out_o.tx_byte !== want.tx_byte)
          report_mismatch("tx_byte", 32'(out_o.tx_byte), 32'(want.tx_byte));
        if (out_o.release_select !== want.release_select)
          report_mismatch("release_select", 32'(out_o.release_select),
                          32'(want.release_select));
        if (out_o.reply_value !== want.reply_value)
          report_mismatch("reply_value", 32'(out_o.reply_value), 32'(want.reply_value));
        if (out_o.last !== want.last)
          report_mismatch("last", 32'(out_o.last), 32'(want.last));
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= !steady && rst_ni && ($urandom_range(99) < 33);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    in_t        b;
    bit         eff;
    int         effective_cnt;
    int         w;
    int         pick;
    int         roll;
    logic [3:0] op;

    seq          = ST_IDLE;
    req          = 3'h0;
    cur_addr     = 24'h0;
    remaining    = 16'h0;
    page_left    = 0;
    id_acc       = 24'h0;
    status_hold  = 16'h0;
    mismatches   = 0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_i       <= '0;

    add_row(mk_req(OP_RX, '0, '0, 1'b0, '0, '0, 8'hFF), 0, '0, DRAIN_NONE);
    add_row(mk_req(OP_PROG_BYTE, '0, '0, 1'b0, '0, 8'hFF, '0), 0, '0, DRAIN_NONE);
    add_row(mk_req(4'hF, 24'hFFFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF, 8'hFF), 0, '0,
            DRAIN_NONE);
    add_row(mk_req(4'h9, '0, '0, 1'b0, '0, '0, '0), 0, '0, DRAIN_NONE);
    add_row(mk_req(OP_DEVID, '0, '0, 1'b0, '0, '0, '0), 1,
            flash_beat(KIND_TX, CMD_DEVID, 1'b0, '0, 1'b1), DRAIN_NONE);
    // request while busy
    add_row(mk_req(OP_JEDEC, 24'hFFFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF, 8'hFF), 0, '0,
            DRAIN_IDLE);
    add_row(mk_req(OP_JEDEC, '0, '0, 1'b0, '0, '0, '0), 1,
            flash_beat(KIND_TX, CMD_JEDEC, 1'b0, '0, 1'b1), DRAIN_IDLE);
    add_row(mk_req(OP_RD_STATUS, '0, '0, 1'b0, '0, '0, '0), 1,
            flash_beat(KIND_TX, CMD_RDSR0, 1'b0, '0, 1'b1), DRAIN_IDLE);
    add_row(mk_req(OP_RD_STATUS, '0, '0, 1'b1, '0, '0, '0), 1,
            flash_beat(KIND_TX, CMD_RDSR1, 1'b0, '0, 1'b1), DRAIN_IDLE);
    add_row(mk_req(OP_WR_STATUS, '0, '0, 1'b0, 16'hFFFF, '0, '0), 1,
            flash_beat(KIND_TX, CMD_WREN, 1'b1, '0, 1'b1), DRAIN_IDLE);
    add_row(mk_req(OP_WR_STATUS, '0, '0, 1'b0, 16'h0000, '0, '0), -1, '0, DRAIN_IDLE);
    add_row(mk_req(OP_ERASE, 24'hFFFFFF, '0, 1'b0, '0, '0, '0), 1,
            flash_beat(KIND_TX, CMD_WREN, 1'b1, '0, 1'b1), DRAIN_IDLE);
    add_row(mk_req(OP_ERASE, 24'h000000, '0, 1'b0, '0, '0, '0), -1, '0, DRAIN_IDLE);
    // empty read
    add_row(mk_req(OP_READ, 24'h000000, 16'd0, 1'b0, '0, '0, '0), 1,
            flash_beat(KIND_TX, CMD_READ, 1'b0, '0, 1'b1), DRAIN_IDLE);
    add_row(mk_req(OP_READ, 24'hFFFFFE, 16'd1, 1'b0, '0, '0, '0), -1, '0, DRAIN_IDLE);
    add_row(mk_req(OP_READ, 24'h000100, 16'd3, 1'b0, '0, '0, '0), -1, '0, DRAIN_IDLE);
    // empty program
    add_row(mk_req(OP_PROG_START, 24'h000000, 16'd0, 1'b0, '0, '0, '0), 1,
            flash_beat(KIND_TX, CMD_WREN, 1'b1, '0, 1'b1), DRAIN_IDLE);
    // page crossing with address wrap
    add_row(mk_req(OP_PROG_START, 24'hFFFFFF, 16'd2, 1'b0, '0, '0, '0), -1, '0, DRAIN_IDLE);
    // ends on a page boundary, no trailing page
    add_row(mk_req(OP_PROG_START, 24'h0000F0, 16'd16, 1'b0, '0, '0, '0), -1, '0, DRAIN_IDLE);
    add_row(mk_req(OP_PROG_START, 24'h000100, 16'd256, 1'b0, '0, '0, '0), -1, '0,
            DRAIN_IDLE);
    // stray beats while a page waits for data
    add_row(mk_req(OP_PROG_START, 24'h000010, 16'd1, 1'b0, '0, '0, '0), -1, '0, DRAIN_WAIT);
    add_row(mk_req(OP_RX, '0, '0, 1'b0, '0, '0, 8'hFF), 0, '0, DRAIN_NONE);
    add_row(mk_req(OP_READ, 24'hFFFFFF, 16'hFFFF, 1'b1, '0, '0, '0), 0, '0, DRAIN_NONE);
    add_row(mk_req(OP_PROG_BYTE, '0, '0, 1'b0, '0, 8'h00, '0), -1, '0, DRAIN_IDLE);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      issue_beat(rows[i].beat, rows[i].n_typed, rows[i].want, eff);
      if (rows[i].drain != DRAIN_NONE) begin
        while (seq != ST_IDLE && !(rows[i].drain == DRAIN_WAIT && seq == ST_PG_WAIT))
          issue_beat(flash_reply_beat(), -1, '0, eff);
      end
    end

    effective_cnt = 0;
    while (effective_cnt < RANDOM_BEATS) begin
      if (seq == ST_IDLE) begin
        if ($urandom_range(99) < 10) begin
          op = 4'($urandom_range(6, 15));
          if (op == OP_READ) op = OP_RX;
          b = rand_fields(op);
        end else begin
          pick = $urandom_range(0, 6);
          b = rand_fields((pick == 6) ? OP_READ : 4'(pick));
          case ($urandom_range(0, 3))
            0: b.flash_address[7:4] = 4'hF;
            1: b.flash_address = 24'hFFFFFF - 24'($urandom_range(0, 8));
            default: ;
          endcase
          roll = $urandom_range(99);
          if (roll < 10) b.byte_count = 16'd0;
          else if (roll < 85) b.byte_count = 16'($urandom_range(1, 24));
          else if (roll < 98) b.byte_count = 16'($urandom_range(25, 300));
          else b.byte_count = 16'($urandom_range(301, 600));
        end
      end else if ($urandom_range(99) < 12) begin
        b = rand_fields(4'($urandom_range(0, 15)));
      end else begin
        b = flash_reply_beat();
      end
      issue_beat(b, -1, '0, eff);
      if (eff) begin
        effective_cnt++;
        if (effective_cnt == 250) hold_off_req = 1'b1;
        if (effective_cnt == 550) begin
          in_valid_i <= 1'b0;
          while (flash_beats_due.size() != 0) @(posedge clk_i);
        end
        steady = (effective_cnt >= 700 && effective_cnt < 880);
      end
    end

    in_valid_i <= 1'b0;
    for (w = 0; w < 20000 && flash_beats_due.size() != 0; w++) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (flash_beats_due.size() != 0)
      report_mismatch("results never arrived", 32'(flash_beats_due.size()), 32'h0);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
